[hw/rtl/crcfr_pkg.sv]
// ============================================================================
// crcfr_pkg
// Shared widths, register codes, reset values and CRC-8 helpers for the
// framed packet receiver.
// ============================================================================
package crcfr_pkg;

    localparam int WORD_W  = 8;
    localparam int INDEX_W = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [WORD_W-1:0] CRC_POLY        = 8'h07;
    localparam logic [WORD_W-1:0] START_MARKER_RST = 8'hFF;
    localparam logic [WORD_W-1:0] END_MARKER_RST   = 8'hDD;

    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    function automatic t_word crc8_byte(input t_word crc, input t_word b);
        t_word v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Columns of the map that advances a byte through n zero bytes.
    function automatic logic [8*WORD_W-1:0] crc8_cols(input int n);
        logic [8*WORD_W-1:0] cols;
        t_word               v;
        cols = '0;
        for (int j = 0; j < WORD_W; j++) begin
            v = t_word'(1) << j;
            for (int k = 0; k < n; k++) begin
                v = crc8_byte(v, '0);
            end
            cols[j*WORD_W +: WORD_W] = v;
        end
        return cols;
    endfunction

    function automatic t_word crc8_apply(input logic [8*WORD_W-1:0] cols,
                                         input t_word b);
        t_word acc;
        acc = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (b[j]) begin
                acc = acc ^ cols[j*WORD_W +: WORD_W];
            end
        end
        return acc;
    endfunction

endpackage

[hw/rtl/crcfr_window.sv]
// ============================================================================
// crcfr_window
// Sliding byte window with running CRC-8 and frame match on each new word.
// ============================================================================
module crcfr_window
    import crcfr_pkg::*;
#(
    parameter int PAYLOAD_LEN = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  t_word                         i_byte,
    input  t_word                         i_start_marker,
    input  t_word                         i_end_marker,
    output logic                          o_hit,
    output logic [PAYLOAD_LEN*WORD_W-1:0] o_payload
);

    localparam int WIN_LEN = PAYLOAD_LEN + 3;
    localparam int FILL_W  = $clog2(WIN_LEN + 1);
    localparam int OUT_POS = WIN_LEN - PAYLOAD_LEN;
    localparam logic [8*WORD_W-1:0] K_COLS = crc8_cols(PAYLOAD_LEN + 1);

    t_word              r_win [WIN_LEN];
    t_word              n_win [WIN_LEN];
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    t_word              r_crc;
    t_word              r_crc_d1;
    t_word              n_crc;
    logic               full_next;

    always_comb begin
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            n_win[k] = r_win[k+1];
        end
        n_win[WIN_LEN-1] = i_byte;
        n_fill = (r_fill == FILL_W'(WIN_LEN)) ? r_fill : r_fill + FILL_W'(1);
        n_crc  = crc8_byte(r_crc, i_byte) ^ crc8_apply(K_COLS, r_win[OUT_POS]);
    end

    assign full_next = (r_fill >= FILL_W'(WIN_LEN - 1));

    assign o_hit = i_accept && full_next
                && (i_byte == i_end_marker)
                && (r_win[1] == i_start_marker)
                && (r_crc_d1 == r_win[WIN_LEN-1]);

    always_comb begin
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            o_payload[i*WORD_W +: WORD_W] = r_win[i+2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_fill   <= '0;
            r_crc    <= '0;
            r_crc_d1 <= '0;
        end else if (i_accept) begin
            r_win    <= n_win;
            r_fill   <= n_fill;
            r_crc    <= n_crc;
            r_crc_d1 <= r_crc;
        end
    end

endmodule

[hw/rtl/crcfr_emit.sv]
// ============================================================================
// crcfr_emit
// Two frame slots: the active one streams payload words out, the pending one
// holds a second validated frame until the active run ends.
// ============================================================================
module crcfr_emit
    import crcfr_pkg::*;
#(
    parameter int PAYLOAD_LEN = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hit,
    input  logic [PAYLOAD_LEN*WORD_W-1:0] i_payload,
    input  logic                          i_stall,
    output logic                          o_busy,
    output logic                          o_valid,
    output t_word                         o_payload_byte,
    output logic [INDEX_W-1:0]            o_payload_index,
    output logic                          o_last_of_frame
);

    localparam int IDX_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

    logic                          r_act_v;
    logic                          n_act_v;
    logic [PAYLOAD_LEN*WORD_W-1:0] r_act_data;
    logic [PAYLOAD_LEN*WORD_W-1:0] n_act_data;
    logic [IDX_W-1:0]              r_idx;
    logic [IDX_W-1:0]              n_idx;
    logic                          r_pnd_v;
    logic                          n_pnd_v;
    logic [PAYLOAD_LEN*WORD_W-1:0] r_pnd_data;
    logic [PAYLOAD_LEN*WORD_W-1:0] n_pnd_data;
    logic                          out_acc;
    logic                          act_done;
    logic [IDX_W+INDEX_W-1:0]      idx_ext;

    assign out_acc  = r_act_v && !i_stall;
    assign act_done = out_acc && (r_idx == LAST_IDX);

    always_comb begin
        n_act_v    = r_act_v;
        n_act_data = r_act_data;
        n_idx      = r_idx;
        n_pnd_v    = r_pnd_v;
        n_pnd_data = r_pnd_data;
        if (out_acc) begin
            n_act_data = r_act_data >> WORD_W;
            n_idx      = r_idx + IDX_W'(1);
        end
        if (act_done) begin
            n_act_v = 1'b0;
            n_idx   = '0;
        end
        if (act_done && r_pnd_v) begin
            n_act_v    = 1'b1;
            n_act_data = r_pnd_data;
            n_pnd_v    = 1'b0;
        end
        if (i_hit) begin
            if (!n_act_v) begin
                n_act_v    = 1'b1;
                n_act_data = i_payload;
                n_idx      = '0;
            end else begin
                n_pnd_v    = 1'b1;
                n_pnd_data = i_payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_v <= 1'b0;
            r_pnd_v <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_act_v <= n_act_v;
            r_pnd_v <= n_pnd_v;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act_data <= n_act_data;
        r_pnd_data <= n_pnd_data;
    end

    assign idx_ext         = {{INDEX_W{1'b0}}, r_idx};
    assign o_busy          = r_pnd_v;
    assign o_valid         = r_act_v;
    assign o_payload_byte  = r_act_data[WORD_W-1:0];
    assign o_payload_index = idx_ext[INDEX_W-1:0];
    assign o_last_of_frame = (r_idx == LAST_IDX);

endmodule

[hw/rtl/crc8_framed_packet_receiver.sv]
// ============================================================================
// crc8_framed_packet_receiver
// Takes one received word per cycle into a sliding window of PAYLOAD_LEN + 3
// words and checks it for a frame: start marker, PAYLOAD_LEN payload words,
// CRC-8 (poly 0x07, init 0, MSB first) over the payload, end marker. Each
// valid frame comes out as PAYLOAD_LEN words, index 0 first, last flag on the
// final word, one per cycle while i_stall is low. An input word is taken in
// each cycle with i_valid high and o_stall low and checked in the cycle it is
// taken; a frame that validates while another run is still streaming waits
// in a pending slot, and input stalls only while that slot is full. The
// markers sit at byte addresses 0 (start) and 4 (end) of the APB port and
// reset to 0xFF and 0xDD.
// ============================================================================
module crc8_framed_packet_receiver
    import crcfr_pkg::*;
#(
    parameter int PAYLOAD_LEN = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [WORD_W-1:0]  i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_payload_byte,
    output logic [INDEX_W-1:0] o_payload_index,
    output logic               o_last_of_frame,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_word                         r_start_marker;
    t_word                         r_end_marker;
    logic                          cfg_wr;
    logic                          in_acc;
    logic                          hit;
    logic [PAYLOAD_LEN*WORD_W-1:0] payload;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_START_MARKER: r_start_marker <= pwdata[WORD_W-1:0];
                REG_END_MARKER:   r_end_marker   <= pwdata[WORD_W-1:0];
                default:          r_start_marker <= r_start_marker;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_START_MARKER: prdata[WORD_W-1:0] = r_start_marker;
            REG_END_MARKER:   prdata[WORD_W-1:0] = r_end_marker;
            default:          prdata = '0;
        endcase
    end

    assign in_acc = i_valid && !o_stall;

    crcfr_window #(
        .PAYLOAD_LEN(PAYLOAD_LEN)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_acc),
        .i_byte         (i_rx_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_hit          (hit),
        .o_payload      (payload)
    );

    crcfr_emit #(
        .PAYLOAD_LEN(PAYLOAD_LEN)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_hit           (hit),
        .i_payload       (payload),
        .i_stall         (i_stall),
        .o_busy          (o_stall),
        .o_valid         (o_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_last_of_frame (o_last_of_frame)
    );

`ifndef NO_ASSERTIONS
    a_pending_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("pending frame held with no active run");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_frame) |=> o_valid)
        else $error("payload run ended before its last word");

    a_index_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_frame) |=>
            (o_payload_index == INDEX_W'($past(o_payload_index) + INDEX_W'(1))))
        else $error("payload index did not advance by one");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_frame) |-> (o_payload_index == INDEX_W'(PAYLOAD_LEN - 1)))
        else $error("last flag on wrong payload index");
`endif

endmodule

[bench/tb_crc8_framed_packet_receiver.sv]
// ============================================================================
// tb_crc8_framed_packet_receiver
// Self-checking bench for the CRC-8 framed packet receiver. A directed table
// covers the fill-up after reset, zero and equal markers, and overlapping
// frames. Random traffic follows: mostly well-formed frames with random
// payloads, plus corrupted frames and noise, under several marker settings.
// Payload words are checked against a window predictor or a row fill. Random
// gaps on the input and random stalls on the output are applied in every
// phase but the last, which runs at full rate.
// ============================================================================
`timescale 1ns / 100ps

module tb_crc8_framed_packet_receiver;
    import crcfr_pkg::*;

    localparam int PAYLOAD_LEN  = 12;
    localparam int WIN_LEN      = PAYLOAD_LEN + 3;
    localparam int DRAIN_CYCLES = 2 * PAYLOAD_LEN + 8;
    localparam int PHASE_BYTES  = 62;
    localparam int NUM_PHASES   = 5;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_FRAME_OF,
        ROW_SET_MARKERS
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_word     value;
        t_word     aux;
    } t_stim_row;

    typedef struct packed {
        t_word              data;
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_payload_word;

    localparam int DIRECTED_ROWS = 27;
    localparam t_stim_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{ROW_SET_MARKERS, 8'h00, 8'h00},
        '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00},
        '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00},
        '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00},
        '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00},
        '{ROW_NONE, 8'h00, 8'h00}, '{ROW_NONE, 8'h00, 8'h00},
        '{ROW_FRAME_OF, 8'h00, 8'h00}, '{ROW_FRAME_OF, 8'h00, 8'h00},
        '{ROW_SET_MARKERS, 8'hFF, 8'hDD},
        '{ROW_PREDICT, 8'hFF, 8'h00}, '{ROW_PREDICT, 8'h00, 8'h00},
        '{ROW_PREDICT, 8'h80, 8'h00}, '{ROW_PREDICT, 8'h7F, 8'h00},
        '{ROW_PREDICT, 8'h01, 8'h00}, '{ROW_PREDICT, 8'hFE, 8'h00},
        '{ROW_PREDICT, 8'hAA, 8'h00}, '{ROW_PREDICT, 8'h55, 8'h00},
        '{ROW_PREDICT, 8'hDD, 8'h00}
    };

    logic               i_clk;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic [WORD_W-1:0]  i_rx_byte       = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic [WORD_W-1:0]  o_payload_byte;
    logic [INDEX_W-1:0] o_payload_index;
    logic               o_last_of_frame;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [ADDR_W-1:0]  paddr           = '0;
    logic [DATA_W-1:0]  pwdata          = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    t_row_kind     rx_tag_kind = ROW_PREDICT;
    t_word         rx_tag_fill = '0;

    t_word         rx_window [WIN_LEN];
    int            rx_fill        = 0;
    t_word         start_mark     = START_MARKER_RST;
    t_word         end_mark       = END_MARKER_RST;
    t_payload_word pending_payload [$];

    int            mismatch_count = 0;
    int            rx_sent        = 0;
    int            frames_seen    = 0;
    int            words_checked  = 0;
    int            marker_writes  = 0;
    int            stall_run      = 0;
    bit            quiet_tail     = 1'b0;

    crc8_framed_packet_receiver #(
        .PAYLOAD_LEN(PAYLOAD_LEN)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_payload_index(o_payload_index),
        .o_last_of_frame(o_last_of_frame),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("crc8_framed_packet_receiver: mismatch");
        $finish;
    end

    initial begin
        for (int i = 0; i < WIN_LEN; i++) begin
            rx_window[i] = '0;
        end
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic t_word crc_next(input t_word crc, input t_word b);
        t_word r;
        r = crc ^ b;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // Shift one byte into the window; return 1 when the window holds a frame.
    function automatic bit shift_in_rx(input t_word b);
        t_word crc;
        crc = '0;
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            rx_window[i] = rx_window[i+1];
        end
        rx_window[WIN_LEN-1] = b;
        if (rx_fill < WIN_LEN) begin
            rx_fill++;
        end
        if (rx_fill < WIN_LEN || rx_window[WIN_LEN-1] != end_mark ||
            rx_window[0] != start_mark) begin
            return 1'b0;
        end
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            crc = crc_next(crc, rx_window[1+i]);
        end
        return crc == rx_window[WIN_LEN-2];
    endfunction

    always @(posedge i_clk) begin : check_port
        t_payload_word want;
        t_payload_word got;
        bit            frame_ok;
        if (i_rst_n && i_valid && !o_stall) begin
            frame_ok = shift_in_rx(i_rx_byte);
            if (frame_ok) begin
                frames_seen++;
            end
            for (int k = 0; k < PAYLOAD_LEN; k++) begin
                want.index = INDEX_W'(k);
                want.last  = (k == PAYLOAD_LEN - 1);
                case (rx_tag_kind)
                    ROW_FRAME_OF: begin
                        want.data = rx_tag_fill;
                        pending_payload.push_back(want);
                    end
                    ROW_PREDICT: begin
                        want.data = rx_window[1+k];
                        if (frame_ok) begin
                            pending_payload.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_payload_byte, o_payload_index, o_last_of_frame};
            if (pending_payload.size() == 0) begin
                report_mismatch($sformatf("unexpected word %02h index %0d last %0b",
                                          got.data, got.index, got.last));
            end else begin
                want = pending_payload.pop_front();
                words_checked++;
                if (got.data !== want.data) begin
                    report_mismatch($sformatf("payload_byte expected %02h got %02h",
                                              want.data, got.data));
                end
                if (got.index !== want.index) begin
                    report_mismatch($sformatf("payload_index expected %0d got %0d",
                                              want.index, got.index));
                end
                if (got.last !== want.last) begin
                    report_mismatch($sformatf("last_of_frame expected %0b got %0b",
                                              want.last, got.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_stall   <= 1'b1;
            stall_run <= $urandom_range(0, 7);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_rx_byte(input t_word b, input t_row_kind kind, input t_word fill);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_rx_byte   <= b;
        rx_tag_kind <= kind;
        rx_tag_fill <= fill;
        do @(posedge i_clk); while (o_stall);
        rx_sent++;
    endtask

    // Drop valid, wait for every pending word, then let the pipeline drain.
    task automatic settle_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_payload.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_marker(input logic reg_sel, input t_word val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'($urandom()), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[WORD_W-1:0] !== val) begin
            report_mismatch($sformatf("marker readback at %0d expected %02h got %02h",
                                      {reg_sel, 2'b00}, val, prdata[WORD_W-1:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        marker_writes++;
    endtask

    task automatic set_markers(input t_word s, input t_word e);
        write_marker(REG_START_MARKER, s);
        start_mark = s;
        write_marker(REG_END_MARKER, e);
        end_mark = e;
    endtask

    function automatic t_word random_rx_byte();
        case ($urandom_range(0, 7))
            0:       return start_mark;
            1:       return end_mark;
            default: return t_word'($urandom());
        endcase
    endfunction

    task automatic send_random_frame();
        t_word body [PAYLOAD_LEN];
        t_word crc;
        int    flaw;
        crc  = '0;
        flaw = $urandom_range(0, 11);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            body[i] = random_rx_byte();
            crc     = crc_next(crc, body[i]);
        end
        if (flaw == 3) begin
            body[$urandom_range(0, PAYLOAD_LEN - 1)] ^= t_word'($urandom_range(1, 255));
        end
        send_rx_byte(flaw == 1 ? start_mark ^ t_word'($urandom_range(1, 255)) : start_mark,
                     ROW_PREDICT, '0);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            send_rx_byte(body[i], ROW_PREDICT, '0);
        end
        send_rx_byte(flaw == 0 ? crc ^ t_word'($urandom_range(1, 255)) : crc,
                     ROW_PREDICT, '0);
        send_rx_byte(flaw == 2 ? end_mark ^ t_word'($urandom_range(1, 255)) : end_mark,
                     ROW_PREDICT, '0);
    endtask

    initial begin
        int    phase_end;
        t_word m;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_SET_MARKERS) begin
                settle_idle();
                set_markers(DIRECTED[r].value, DIRECTED[r].aux);
            end else begin
                send_rx_byte(DIRECTED[r].value, DIRECTED[r].kind, DIRECTED[r].aux);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_idle();
            m = t_word'($urandom());
            case (p)
                0:       set_markers(START_MARKER_RST, END_MARKER_RST);
                1:       set_markers(8'h00, 8'hFF);
                3:       set_markers(m, m);
                default: set_markers(t_word'($urandom()), t_word'($urandom()));
            endcase
            quiet_tail = (p == NUM_PHASES - 1);
            phase_end  = rx_sent + PHASE_BYTES;
            while (rx_sent < phase_end) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_random_frame();
                end else begin
                    repeat ($urandom_range(1, 6)) send_rx_byte(random_rx_byte(), ROW_PREDICT, '0);
                end
            end
        end

        settle_idle();
        $display("Sent %0d rx bytes under %0d marker writes; %0d frames recognized.",
                 rx_sent, marker_writes, frames_seen);
        $display("Checked %0d payload words; %0d errors.", words_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("crc8_framed_packet_receiver: match");
        end else begin
            $display("crc8_framed_packet_receiver: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_window.sv
hw/rtl/crcfr_emit.sv
hw/rtl/crc8_framed_packet_receiver.sv
bench/tb_crc8_framed_packet_receiver.sv
